FILE: rtl/vesg_pkg.sv
//------------------------------------------------------------------------------
// vesg_pkg
// Shared types and constants of the VARX series generator.
//------------------------------------------------------------------------------
`default_nettype none
package vesg_pkg;

  localparam int unsigned VAL_W  = 24;
  localparam int unsigned ACC_W  = 40;
  localparam int unsigned TIDX_W = 7;
  localparam int unsigned IN_EXO = 4;
  localparam int unsigned IN_DRAWS = 4;
  localparam int unsigned RESULT_CAP = 4;

  localparam logic [2:0] REG_NUM_VARS = 3'd0;
  localparam logic [2:0] REG_NUM_LAGS = 3'd1;
  localparam logic [2:0] REG_NUM_EXO  = 3'd2;
  localparam logic [2:0] REG_BURN_IN  = 3'd3;
  localparam logic [2:0] REG_SER_LEN  = 3'd4;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MAC,
    ST_STORE,
    ST_EMIT
  } vesg_state_t;

  // term kind selects the multiplicand operand
  typedef enum logic [1:0] {
    TK_AR,
    TK_EXO,
    TK_MIX,
    TK_CONST
  } vesg_term_t;

  typedef struct packed {
    logic       acc_clear;
    logic       mac_en;
    logic       store_var;
    logic       shift_hist;
  } vesg_cmd_t;

  function automatic logic signed [VAL_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(signed'(24'sh7FFFFF));
    lo = ACC_W'(signed'(24'sh800000));
    if (v > hi) return 24'sh7FFFFF;
    if (v < lo) return 24'sh800000;
    return v[VAL_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vesg_datapath.sv
//------------------------------------------------------------------------------
// vesg_datapath
// Coefficient memory, history registers and one multiply-accumulate unit.
//------------------------------------------------------------------------------
`default_nettype none
module vesg_datapath #(
  parameter int unsigned MAX_VARS    = 4,
  parameter int unsigned MAX_LAGS    = 4,
  parameter int unsigned TABLE_DEPTH = 128,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
  localparam int unsigned LW = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // table write port
  input  wire logic                              tab_we,
  input  wire logic [vesg_pkg::TIDX_W-1:0]       tab_widx,
  input  wire logic signed [vesg_pkg::VAL_W-1:0] tab_wdata,
  // term read: address and operand select; coefficient and operand are registered before the multiply
  input  wire logic [AW-1:0]                     rd_addr,
  input  wire vesg_pkg::vesg_term_t              rd_kind,
  input  wire logic [LW-1:0]                     rd_lag,
  input  wire logic [2:0]                        rd_src,
  input  wire logic                              rd_valid,
  input  wire logic [vesg_pkg::VAL_W*4-1:0]      exo_in,
  input  wire logic [vesg_pkg::VAL_W*4-1:0]      draw_in,
  input  wire vesg_pkg::vesg_cmd_t               cmd,
  input  wire logic [VW-1:0]                     store_var,
  input  wire logic [2:0]                        nv,
  input  wire logic                              hist_clear,
  output logic signed [vesg_pkg::VAL_W-1:0]      store_val
);
  import vesg_pkg::*;

  logic signed [VAL_W-1:0] mem [TABLE_DEPTH];
  logic signed [VAL_W-1:0] coef_r;
  logic signed [VAL_W-1:0] opnd_r;
  logic                    p_valid_r;
  logic signed [2*VAL_W-1:0] prod_r;
  logic                    prod_valid_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [VAL_W-1:0] hist_r [MAX_LAGS][MAX_VARS];
  logic signed [VAL_W-1:0] vals_r [MAX_VARS];
  logic signed [VAL_W-1:0] opnd_nxt;

  always_ff @(posedge clk) begin
    if (tab_we && (32'(tab_widx) < TABLE_DEPTH)) begin
      mem[tab_widx[AW-1:0]] <= tab_wdata;
    end
    coef_r <= mem[rd_addr];
  end

  always_comb begin
    opnd_nxt = '0;
    unique case (rd_kind)
      TK_AR: begin
        opnd_nxt = (32'(rd_src) < MAX_VARS) ? hist_r[rd_lag][rd_src[VW-1:0]] : '0;
      end
      TK_EXO:   opnd_nxt = exo_in[rd_src[1:0]*VAL_W +: VAL_W];
      TK_MIX:   opnd_nxt = draw_in[rd_src[1:0]*VAL_W +: VAL_W];
      TK_CONST: opnd_nxt = 24'sd4096;
      default:  opnd_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    opnd_r <= opnd_nxt;
    prod_r <= coef_r * opnd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r    <= 1'b0;
      prod_valid_r <= 1'b0;
    end else begin
      p_valid_r    <= rd_valid;
      prod_valid_r <= p_valid_r;
    end
  end

  // constant enters as coef*1.0, exact after the shift
  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_r <= '0;
    end else if (prod_valid_r) begin
      acc_r <= acc_r + ACC_W'(prod_r >>> 12);
    end
  end

  assign store_val = sat24(acc_r);

  always_ff @(posedge clk) begin
    if (cmd.store_var) begin
      vals_r[store_var] <= store_val;
    end
  end

  // a burn-in step stores its last variable in the same cycle as the shift
  always_ff @(posedge clk) begin
    if (!rst_n || hist_clear) begin
      for (int l = 0; l < MAX_LAGS; l++)
        for (int v = 0; v < MAX_VARS; v++) hist_r[l][v] <= '0;
    end else if (cmd.shift_hist) begin
      for (int l = MAX_LAGS - 1; l > 0; l--)
        for (int v = 0; v < MAX_VARS; v++) hist_r[l][v] <= hist_r[l-1][v];
      for (int v = 0; v < MAX_VARS; v++)
        hist_r[0][v] <= (v < 32'(nv)) ?
                        ((cmd.store_var && (store_var == VW'(v))) ? store_val : vals_r[v]) :
                        '0;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/vesg_ctrl.sv
//------------------------------------------------------------------------------
// vesg_ctrl
// Sequencer: walks the terms of each variable and hands out results.
//------------------------------------------------------------------------------
`default_nettype none
module vesg_ctrl #(
  parameter int unsigned MAX_VARS    = 4,
  parameter int unsigned MAX_LAGS    = 4,
  parameter int unsigned MAX_EXO     = 4,
  parameter int unsigned TABLE_DEPTH = 128,
  localparam int unsigned AW = $clog2(TABLE_DEPTH),
  localparam int unsigned VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1,
  localparam int unsigned LW = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_go,
  input  wire logic [2:0]           nv,
  input  wire logic [2:0]           nl,
  input  wire logic [2:0]           ne,
  input  wire logic                 warm,
  input  wire logic                 emit_step,
  input  wire logic                 out_free,
  output logic                      busy,
  output logic [AW-1:0]             rd_addr,
  output vesg_pkg::vesg_term_t      rd_kind,
  output logic [LW-1:0]             rd_lag,
  output logic [2:0]                rd_src,
  output logic                      rd_valid,
  output vesg_pkg::vesg_cmd_t       cmd,
  output logic [VW-1:0]             cur_var,
  output logic                      push_out,
  output logic                      step_done
);
  import vesg_pkg::*;

  localparam int unsigned EXO_BASE   = MAX_LAGS * MAX_VARS * MAX_VARS;
  localparam int unsigned MIX_BASE   = EXO_BASE + MAX_VARS * MAX_EXO;
  localparam int unsigned CONST_BASE = MIX_BASE + MAX_VARS * MAX_VARS;

  vesg_state_t state_r, state_nxt;
  vesg_term_t  kind_r, kind_nxt;
  logic [LW-1:0] lag_r, lag_nxt;
  logic [2:0]    src_r, src_nxt;
  logic [VW-1:0] var_r, var_nxt;
  logic [1:0]    drain_r, drain_nxt;
  logic          last_term;
  logic          emit_r, emit_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= TK_CONST;
      lag_r   <= '0;
      src_r   <= '0;
      var_r   <= '0;
      drain_r <= '0;
      emit_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      lag_r   <= lag_nxt;
      src_r   <= src_nxt;
      var_r   <= var_nxt;
      drain_r <= drain_nxt;
      emit_r  <= emit_nxt;
    end
  end

  always_comb begin
    rd_addr = '0;
    unique case (kind_r)
      TK_AR:    rd_addr = AW'(32'(lag_r) * MAX_VARS * MAX_VARS + 32'(var_r) * MAX_VARS
                              + 32'(src_r));
      TK_EXO:   rd_addr = AW'(EXO_BASE + 32'(var_r) * MAX_EXO + 32'(src_r));
      TK_MIX:   rd_addr = AW'(MIX_BASE + 32'(var_r) * MAX_VARS + 32'(src_r));
      TK_CONST: rd_addr = AW'(CONST_BASE + 32'(var_r));
      default:  rd_addr = '0;
    endcase
  end
  assign rd_kind = kind_r;
  assign rd_lag  = lag_r;
  assign rd_src  = src_r;
  assign cur_var = var_r;

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    lag_nxt   = lag_r;
    src_nxt   = src_r;
    var_nxt   = var_r;
    drain_nxt = drain_r;
    emit_nxt  = emit_r;
    cmd       = '0;
    rd_valid  = 1'b0;
    push_out  = 1'b0;
    step_done = 1'b0;
    last_term = 1'b0;
    busy      = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (step_go) begin
          state_nxt = ST_MAC;
          kind_nxt  = TK_CONST;
          var_nxt   = '0;
          emit_nxt  = emit_step;
          cmd.acc_clear = 1'b1;
        end
      end
      ST_MAC: begin
        rd_valid = 1'b1;
        priority case (kind_r)
          TK_CONST: begin
            if (!warm) last_term = 1'b1;
            else begin
              kind_nxt = TK_AR; lag_nxt = '0; src_nxt = '0;
            end
          end
          TK_AR: begin
            if (src_r == nv - 3'd1) begin
              src_nxt = '0;
              if (32'(lag_r) == 32'(nl) - 1) begin
                lag_nxt = '0;
                if (ne != 3'd0) kind_nxt = TK_EXO;
                else kind_nxt = TK_MIX;
              end else lag_nxt = lag_r + 1'b1;
            end else src_nxt = src_r + 3'd1;
          end
          TK_EXO: begin
            if (src_r == ne - 3'd1) begin
              src_nxt = '0; kind_nxt = TK_MIX;
            end else src_nxt = src_r + 3'd1;
          end
          default: begin
            if (src_r == nv - 3'd1) last_term = 1'b1;
            else src_nxt = src_r + 3'd1;
          end
        endcase
        if (last_term) begin
          state_nxt = ST_STORE;
          drain_nxt = 2'd3;
        end
      end
      ST_STORE: begin
        // wait for read, operand and product stages to settle
        if (drain_r != 2'd0) drain_nxt = drain_r - 2'd1;
        else begin
          cmd.store_var = 1'b1;
          state_nxt = emit_r ? ST_EMIT : ST_STORE;
          if (!emit_r) begin
            if (32'(var_r) == 32'(nv) - 1) begin
              cmd.shift_hist = 1'b1; step_done = 1'b1; state_nxt = ST_IDLE;
            end else begin
              var_nxt = var_r + 1'b1; kind_nxt = TK_CONST;
              cmd.acc_clear = 1'b1; state_nxt = ST_MAC;
            end
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          push_out = 1'b1;
          if (32'(var_r) == 32'(nv) - 1) begin
            cmd.shift_hist = 1'b1; step_done = 1'b1; state_nxt = ST_IDLE;
          end else begin
            var_nxt = var_r + 1'b1; kind_nxt = TK_CONST;
            cmd.acc_clear = 1'b1; state_nxt = ST_MAC;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

FILE: rtl/var_exogenous_series_generator.sv
//------------------------------------------------------------------------------
// var_exogenous_series_generator
// VARX simulation in Q12.12 with one shared multiply-accumulate unit.
//------------------------------------------------------------------------------
// Usage:
//  in_*  : one request per item. func 0 writes a coefficient entry;
//          func 1 advances one time step.
//  out_* : one request per variable of an emitted step; tlast marks the
//          last variable, tuser carries series_end.
//  cfg_* : register writes, only while idle.
// Step sequence: a step request is taken in the idle state, then each variable
//  walks const + nl*nv AR + ne exo + nv mix terms through the single MAC,
//  one term a cycle, then a pipeline drain, a store and an emit that waits
//  for the receiver. Burn-in steps skip the emit; a step inside the first nl
//  steps walks only the constant. Table writes and steps past the series end
//  do not start the sequencer; the next request is taken in the cycle after
//  a step finishes.
// Reset sets the registers to their defaults and clears step counter and history; the table is undefined
// until written. A stalled receiver holds the sequencer in its emit state;
// the output register keeps its request until taken.
//------------------------------------------------------------------------------
`default_nettype none
module var_exogenous_series_generator #(
  parameter int unsigned MAX_VARS    = 4,
  parameter int unsigned MAX_LAGS    = 4,
  parameter int unsigned MAX_EXO     = 4,
  parameter int unsigned TABLE_DEPTH = 128
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [6:0] table_index, [30:7] table_value, [54:31] exo_0, [78:55] exo_1,
  // [102:79] exo_2, [126:103] exo_3, [150:127] draw_0, [174:151] draw_1,
  // [198:175] draw_2, [222:199] draw_3, rest zero
  input  wire logic [223:0] in_tdata,
  input  wire logic         in_tuser,   // func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // [1:0] var_index, [25:2] value
  output logic              out_tlast,  // last_of_step
  output logic              out_tuser,  // series_end
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data
);
  import vesg_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int unsigned LW = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
  localparam int unsigned VCAP = (MAX_VARS < RESULT_CAP) ? MAX_VARS : RESULT_CAP;
  localparam int unsigned ECAP = (MAX_EXO < IN_EXO) ? MAX_EXO : IN_EXO;

  logic [2:0]  num_vars_r, num_lags_r, num_exo_r;
  logic [15:0] burn_in_r, ser_len_r;
  logic [16:0] step_cnt_r;
  logic [2:0]  nv, nl, ne;
  logic [16:0] total;
  logic        busy, step_go, accept, warm, emit_step;
  logic [2*VAL_W*4-1:0] ops_r;
  logic        last_step_r;
  logic [AW-1:0] rd_addr;
  vesg_term_t  rd_kind;
  logic [LW-1:0] rd_lag;
  logic [2:0]  rd_src;
  logic        rd_valid, push_out, step_done;
  vesg_cmd_t   cmd;
  logic [VW-1:0] cur_var;
  logic signed [VAL_W-1:0] store_val;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_vars_r <= 3'd1; num_lags_r <= 3'd1; num_exo_r <= 3'd0;
      burn_in_r  <= '0;   ser_len_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_VARS: num_vars_r <= cfg_data[2:0];
        REG_NUM_LAGS: num_lags_r <= cfg_data[2:0];
        REG_NUM_EXO:  num_exo_r  <= cfg_data[2:0];
        REG_BURN_IN:  burn_in_r  <= cfg_data;
        REG_SER_LEN:  ser_len_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    nv = num_vars_r;
    if (nv == 3'd0) nv = 3'd1;
    if (32'(nv) > VCAP) nv = 3'(VCAP);
    nl = num_lags_r;
    if (nl == 3'd0) nl = 3'd1;
    if (32'(nl) > MAX_LAGS) nl = 3'(MAX_LAGS);
    ne = num_exo_r;
    if (32'(ne) > ECAP) ne = 3'(ECAP);
  end

  assign total     = 17'(burn_in_r) + 17'(ser_len_r);
  assign in_tready = !busy;
  assign accept    = in_tvalid && in_tready;
  assign step_go   = accept && (in_tuser == FUNC_STEP) && (step_cnt_r < total);
  assign warm      = step_cnt_r >= 17'(nl);
  assign emit_step = step_cnt_r >= 17'(burn_in_r);

  always_ff @(posedge clk) begin
    if (step_go) begin
      ops_r       <= in_tdata[222:31];
      last_step_r <= (step_cnt_r + 17'd1 == total);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) step_cnt_r <= '0;
    else if (step_done) step_cnt_r <= step_cnt_r + 17'd1;
  end

  vesg_ctrl #(.MAX_VARS(MAX_VARS), .MAX_LAGS(MAX_LAGS), .MAX_EXO(MAX_EXO),
              .TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
    .clk, .rst_n, .step_go, .nv, .nl, .ne, .warm, .emit_step, .out_free,
    .busy, .rd_addr, .rd_kind, .rd_lag, .rd_src, .rd_valid, .cmd, .cur_var,
    .push_out, .step_done
  );

  vesg_datapath #(.MAX_VARS(MAX_VARS), .MAX_LAGS(MAX_LAGS),
                  .TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk, .rst_n,
    .tab_we(accept && (in_tuser == FUNC_WRITE)),
    .tab_widx(in_tdata[6:0]),
    .tab_wdata(in_tdata[30:7]),
    .rd_addr, .rd_kind, .rd_lag, .rd_src, .rd_valid,
    .exo_in(ops_r[VAL_W*4-1:0]),
    .draw_in(ops_r[2*VAL_W*4-1:VAL_W*4]),
    .cmd, .store_var(cur_var), .nv, .hist_clear(1'b0), .store_val
  );

  // output register
  assign out_free = !out_tvalid || out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (push_out) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (push_out) begin
      out_tdata <= {6'd0, store_val, 2'(cur_var)};
      out_tlast <= (32'(cur_var) == 32'(nv) - 1);
      out_tuser <= (32'(cur_var) == 32'(nv) - 1) && last_step_r;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/vesg_checker.sv
//------------------------------------------------------------------------------
// vesg_checker
// Port-level checks of the series generator.
//------------------------------------------------------------------------------
`default_nettype none
module vesg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        out_tuser
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("series end without step end");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[31:26] == 6'd0)
    else $error("padding not zero");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !out_tlast |=> !in_tready)
    else $error("input taken mid-step");
endmodule

bind var_exogenous_series_generator vesg_checker u_vesg_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata,
  .out_tlast, .out_tuser
);
`default_nettype wire

FILE: test/tb_var_exogenous_series_generator.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// tb_var_exogenous_series_generator
// Self-checking bench for the VARX series generator.
//------------------------------------------------------------------------------
// The coefficient table is loaded once. Every phase then rewrites a few
// entries and sets the registers, and after that it sends a mix of step
// requests and table rewrites. A built-in predictor keeps its own copy of
// the table, the history, the step counter and the registers. For each
// accepted request it queues the expected results. The monitor checks each
// result against the oldest expectation, field by field. Both sides idle at
// random, and in one phase the receiver holds off for a long stretch.
//------------------------------------------------------------------------------
`default_nettype none
module tb_var_exogenous_series_generator;
  import vesg_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 150;    // a bit over the longest step

  typedef struct packed {
    logic              func;
    logic [6:0]        tidx;
    logic signed [23:0] tval;
    logic [3:0][23:0]  exo;
    logic [3:0][23:0]  draw;
  } step_req_t;

  typedef struct packed {
    logic [1:0]  var_index;
    logic [23:0] value;
    logic        last_of_step;
    logic        series_end;
  } sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [223:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tlast, out_tuser;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  var_exogenous_series_generator DUT (.*);

  always #2 clk = ~clk;

  // predictor state
  logic signed [23:0] coef [128];
  logic signed [23:0] hist [4][4];
  int unsigned steps_done;
  int unsigned nvars_r, nlags_r, nexo_r, burn_r, len_r;

  step_req_t pending_reqs[$];
  sample_t   expected_samples[$];
  int errors = 0;
  int samples_seen = 0;
  int steps_sent = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  int hold_cnt = 0;

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH @%0d: %s", cycles, what);
  endtask

  function automatic longint qmul(input logic signed [23:0] a,
                                  input logic signed [23:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return p >>> 12;
  endfunction

  task automatic predict_step(input step_req_t r);
    int unsigned nv, nl, ne, t;
    longint acc;
    logic signed [23:0] vals [4];
    sample_t smp;
    if (r.func == FUNC_WRITE) begin
      coef[r.tidx] = r.tval;
      return;
    end
    t = steps_done;
    if (t >= burn_r + len_r) return;
    nv = (nvars_r < 1) ? 1 : (nvars_r > 4 ? 4 : nvars_r);
    nl = (nlags_r < 1) ? 1 : (nlags_r > 4 ? 4 : nlags_r);
    ne = (nexo_r > 4) ? 4 : nexo_r;
    for (int j = 0; j < 4; j++) vals[j] = '0;
    for (int j = 0; j < nv; j++) begin
      acc = longint'(coef[96 + j]);
      if (t >= nl) begin
        for (int l = 0; l < nl; l++)
          for (int s = 0; s < nv; s++)
            acc += qmul(coef[l*16 + j*4 + s], hist[l][s]);
        for (int s = 0; s < ne; s++) acc += qmul(coef[64 + j*4 + s], r.exo[s]);
        for (int s = 0; s < nv; s++) acc += qmul(coef[80 + j*4 + s], r.draw[s]);
      end
      if (acc > 64'sd8388607) vals[j] = 24'sh7FFFFF;
      else if (acc < -64'sd8388608) vals[j] = 24'sh800000;
      else vals[j] = acc[23:0];
    end
    for (int l = 3; l > 0; l--)
      for (int s = 0; s < 4; s++) hist[l][s] = hist[l-1][s];
    for (int s = 0; s < 4; s++) hist[0][s] = (s < nv) ? vals[s] : '0;
    steps_done = t + 1;
    if (t < burn_r) return;
    for (int j = 0; j < nv; j++) begin
      smp.var_index = j[1:0];
      smp.value = vals[j];
      smp.last_of_step = (j == nv - 1);
      smp.series_end = (j == nv - 1) && (t + 1 == burn_r + len_r);
      expected_samples.push_back(smp);
    end
  endtask

  // driver: one request offered per cycle, held while the generator is busy, random gaps between
  int gap = 0;
  always @(posedge clk) begin
    step_req_t r;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        r = pending_reqs.pop_front();
        predict_step(r);
        if (r.func == FUNC_STEP) steps_sent++;
      end
      if (in_tvalid && !in_tready) begin
        // hold current request
      end else if (gap > 0) begin
        gap <= gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        r = pending_reqs[0];
        in_tvalid <= 1'b1;
        in_tuser <= r.func;
        in_tdata <= {1'b0, r.draw, r.exo, r.tval, r.tidx};
        gap <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
               ($urandom_range(0, 2) == 0 ? $urandom_range(0, 3) : 0);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver hold-off length, counted in cycles
  always @(posedge clk) begin
    if (hold_off && hold_cnt < 600) hold_cnt <= hold_cnt + 1;
  end

  // monitor with random receiver stalls and an optional long hold-off
  always @(posedge clk) begin
    sample_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[1:0], out_tdata[25:2], out_tlast, out_tuser};
        samples_seen++;
        if (out_tdata[31:26] != '0) report_mismatch("nonzero pad bits in out_tdata");
        if (expected_samples.size() == 0) begin
          report_mismatch($sformatf("unexpected result var=%0d", got.var_index));
        end else begin
          want = expected_samples.pop_front();
          if (got.var_index != want.var_index)
            report_mismatch($sformatf("var_index %0d want %0d", got.var_index, want.var_index));
          if (got.value != want.value)
            report_mismatch($sformatf("value %h want %h (var %0d)", got.value, want.value,
                                      want.var_index));
          if (got.last_of_step != want.last_of_step)
            report_mismatch($sformatf("last_of_step %0b want %0b", got.last_of_step,
                                      want.last_of_step));
          if (got.series_end != want.series_end)
            report_mismatch($sformatf("series_end %0b want %0b", got.series_end,
                                      want.series_end));
        end
      end
      if (hold_off && hold_cnt < 600) begin
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 19) == 0) begin
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= ~out_tready;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUM_VARS: nvars_r = val & 7;
      REG_NUM_LAGS: nlags_r = val & 7;
      REG_NUM_EXO:  nexo_r = val & 7;
      REG_BURN_IN:  burn_r = val;
      REG_SER_LEN:  len_r = val;
      default: ;
    endcase
  endtask

  function automatic logic [23:0] rand_val(input int mode);
    case (mode)
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'hFFFFFF;
      default: return 24'($urandom());
    endcase
  endfunction

  // moderate Q12.12 coefficient, keeps series from saturating every step
  function automatic logic [23:0] rand_coef();
    int k;
    k = $urandom_range(0, 15);
    if (k == 0) return rand_val($urandom_range(0, 3));
    return 24'($signed($urandom_range(0, 4095)) - 2048);
  endfunction

  function automatic step_req_t table_write(input int idx, input logic [23:0] v);
    step_req_t r;
    r = '0;
    r.func = FUNC_WRITE;
    r.tidx = idx[6:0];
    r.tval = v;
    r.exo = {3{$urandom()}};
    r.draw = {3{$urandom()}};
    return r;
  endfunction

  function automatic step_req_t time_step(input bit extreme);
    step_req_t r;
    r.func = FUNC_STEP;
    r.tidx = 7'($urandom());
    r.tval = 24'($urandom());
    for (int i = 0; i < 4; i++) begin
      r.exo[i] = extreme ? rand_val($urandom_range(0, 4)) :
                 24'($signed($urandom_range(0, 16383)) - 8192);
      r.draw[i] = extreme ? rand_val($urandom_range(0, 4)) :
                  24'($signed($urandom_range(0, 16383)) - 8192);
    end
    return r;
  endfunction

  task automatic wait_idle();
    while (pending_reqs.size() != 0 || in_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // rewrite a few table entries, then registers, then a stream of steps
  task automatic run_phase(input int nv, input int nl, input int ne, input int burn,
                           input int len, input int nsteps, input bit extreme,
                           input bit stall);
    for (int i = 0; i < 3; i++)
      pending_reqs.push_back(table_write($urandom_range(0, 99),
                                         extreme ? rand_val($urandom_range(0, 4)) :
                                                   rand_coef()));
    wait_idle();
    // registers change mid-series; step counter and history carry over
    write_reg(REG_NUM_VARS, 16'(nv));
    write_reg(REG_NUM_LAGS, 16'(nl));
    write_reg(REG_NUM_EXO, 16'(ne));
    write_reg(REG_BURN_IN, 16'(burn));
    write_reg(REG_SER_LEN, 16'(len));
    hold_cnt = 0;
    hold_off = stall;
    for (int k = 0; k < nsteps; k++) begin
      if ($urandom_range(0, 7) == 0)
        pending_reqs.push_back(table_write($urandom_range(0, 127), rand_coef()));
      pending_reqs.push_back(time_step(extreme || $urandom_range(0, 9) == 0));
    end
    wait_idle();
    hold_off = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < 128; i++) coef[i] = '0;
    for (int l = 0; l < 4; l++) for (int s = 0; s < 4; s++) hist[l][s] = '0;
    steps_done = 0;
    nvars_r = 1; nlags_r = 1; nexo_r = 0; burn_r = 0; len_r = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    // reset registers: zero series length, steps are ignored
    pending_reqs.push_back(time_step(1'b1));
    pending_reqs.push_back(time_step(1'b1));
    wait_idle();
    // load every entry the layout uses
    for (int i = 0; i < 100; i++)
      pending_reqs.push_back(table_write(i, rand_coef()));
    wait_idle();
    // directed: extreme values, out-of-range registers, burn-in, series end
    run_phase(7, 0, 7, 2, 3, 6, 1'b1, 1'b0);
    run_phase(4, 4, 4, 0, 6, 8, 1'b1, 1'b0);
    // random phases; step counter keeps running, so series_length is set to its maximum
    run_phase(4, 4, 4, 0, 16'hFFFF, 24, 1'b0, 1'b1);
    run_phase(2, 3, 1, 3, 16'hFFFF, 16, 1'b0, 1'b0);
    run_phase(1, 1, 0, 0, 16'hFFFF, 10, 1'b0, 1'b0);
    run_phase(3, 2, 2, 1, 16'hFFFF, 14, 1'b0, 1'b0);
    run_phase(4, 1, 3, 0, 16'hFFFF, 10, 1'b0, 1'b0);
    $display("covered %0d step requests, %0d results checked", steps_sent, samples_seen);
    $display("register extremes, burn-in, series end, table rewrites, long output stall");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: files.f
rtl/vesg_pkg.sv
rtl/vesg_datapath.sv
rtl/vesg_ctrl.sv
rtl/var_exogenous_series_generator.sv
rtl/vesg_checker.sv
test/tb_var_exogenous_series_generator.sv
